FILE: sv/md5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

    // chaining word initial values
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    // per-round additive constants
    localparam logic [31:0] K_TABLE [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amounts, indexed by {phase, round[1:0]}
    localparam logic [4:0] ROT_TABLE [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // kind of block being compressed
    typedef enum logic [1:0] {
        MODE_DATA     = 2'd0,  // sixteen message words
        MODE_MARK     = 2'd1,  // message tail, pad mark, zeros
        MODE_MARK_LEN = 2'd2,  // message tail, pad mark, zeros, length
        MODE_LEN      = 2'd3   // zeros and length only
    } t_mode;

    // controller states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_PREP  = 6'b000100,
        ST_ROUND = 6'b001000,
        ST_FOLD  = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       wr_byte;
        logic       prep;
        logic       step;
        logic       fold;
        logic       restart;
        t_mode      mode;
        logic [1:0] word_sel;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_round;
        logic fill_full;
        logic fill_le55;
    } t_sts;

    // message word picked by a round
    function automatic logic [3:0] f_pick(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] res;
        r4 = rnd[3:0];
        unique case (rnd[5:4])
            2'd0: res = r4;
            2'd1: res = 4'(4'd5 * r4 + 4'd1);
            2'd2: res = 4'(4'd3 * r4 + 4'd5);
            default: res = 4'(4'd7 * r4);
        endcase
        return res;
    endfunction

endpackage

FILE: sv/md5_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_in_if / md5_out_if
// Valid-ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: sv/md5_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: byte intake, block compression, padding and digest output.
// ----------------------------------------------------------------------------
module md5_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_present,
    input  logic          i_eom,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  md5_pkg::t_sts i_sts,
    output md5_pkg::t_cmd o_cmd
);

    md5_pkg::t_state r_state, n_state;
    md5_pkg::t_mode  r_mode, n_mode;
    logic            r_eom, n_eom;
    logic [1:0]      r_idx, n_idx;
    logic            in_acc;
    logic            out_acc;

    assign o_in_ready  = (r_state == md5_pkg::ST_IDLE);
    assign o_out_valid = (r_state == md5_pkg::ST_EMIT);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_eom   = r_eom;
        n_idx   = r_idx;
        o_cmd          = '0;
        o_cmd.mode     = r_mode;
        o_cmd.word_sel = r_idx;
        unique case (r_state)
            md5_pkg::ST_IDLE: begin
                if (in_acc) begin
                    o_cmd.wr_byte = i_present;
                    if (i_present && i_sts.fill_full) begin
                        n_eom   = i_eom;
                        n_mode  = md5_pkg::MODE_DATA;
                        n_state = md5_pkg::ST_PREP;
                    end else if (i_eom) begin
                        n_state = md5_pkg::ST_PAD;
                    end
                end
            end
            md5_pkg::ST_PAD: begin
                n_eom   = 1'b0;
                n_mode  = i_sts.fill_le55 ? md5_pkg::MODE_MARK_LEN : md5_pkg::MODE_MARK;
                n_state = md5_pkg::ST_PREP;
            end
            md5_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = md5_pkg::ST_ROUND;
            end
            md5_pkg::ST_ROUND: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_round) begin
                    n_state = md5_pkg::ST_FOLD;
                end
            end
            md5_pkg::ST_FOLD: begin
                o_cmd.fold = 1'b1;
                unique case (r_mode)
                    md5_pkg::MODE_DATA: begin
                        n_state = r_eom ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
                    end
                    md5_pkg::MODE_MARK: begin
                        n_mode  = md5_pkg::MODE_LEN;
                        n_state = md5_pkg::ST_PREP;
                    end
                    default: begin
                        n_idx   = 2'd0;
                        n_state = md5_pkg::ST_EMIT;
                    end
                endcase
            end
            md5_pkg::ST_EMIT: begin
                if (out_acc) begin
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        o_cmd.restart = 1'b1;
                        n_state       = md5_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = md5_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= md5_pkg::ST_IDLE;
            r_mode  <= md5_pkg::MODE_DATA;
            r_eom   <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_eom   <= n_eom;
            r_idx   <= n_idx;
        end
    end

endmodule

FILE: sv/md5_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_dp
// Block buffer, byte count, chaining words and the one-round-per-cycle unit.
// ----------------------------------------------------------------------------
module md5_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_data_byte,
    input  md5_pkg::t_cmd i_cmd,
    output md5_pkg::t_sts o_sts,
    output logic [31:0]   o_digest
);

    logic [31:0] r_buf [16];
    logic [31:0] r_h [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_pre;
    logic [5:0]  r_round;
    logic [60:0] r_bytes;

    logic [5:0]  fill;
    logic [63:0] bit_len;
    logic [5:0]  next_round;
    logic [3:0]  rd_idx;
    logic [31:0] w;
    logic [31:0] mix;
    logic [31:0] t;
    logic [4:0]  sh;
    logic [63:0] t2;
    logic [31:0] n_b;
    logic [31:0] n_pre;

    assign fill    = r_bytes[5:0];
    assign bit_len = {r_bytes, 3'b000};

    // block word with padding and length laid over the stored bytes
    function automatic logic [31:0] f_pad_word(
        input logic [3:0]     j,
        input logic [31:0]    raw,
        input md5_pkg::t_mode mode,
        input logic [5:0]     fp,
        input logic [63:0]    len
    );
        logic [31:0] res;
        logic [5:0]  p;
        res = raw;
        for (int n = 0; n < 4; n++) begin
            p = {j, 2'(n)};
            unique case (mode)
                md5_pkg::MODE_DATA: res[8*n +: 8] = raw[8*n +: 8];
                md5_pkg::MODE_LEN:  res[8*n +: 8] = 8'h00;
                default: begin
                    if (p == fp) begin
                        res[8*n +: 8] = md5_pkg::PAD_MARK;
                    end else if (p > fp) begin
                        res[8*n +: 8] = 8'h00;
                    end else begin
                        res[8*n +: 8] = raw[8*n +: 8];
                    end
                end
            endcase
            if ((mode == md5_pkg::MODE_MARK_LEN || mode == md5_pkg::MODE_LEN)
                && p >= md5_pkg::LEN_POS) begin
                res[8*n +: 8] = len[{p[2:0], 3'b000} +: 8];
            end
        end
        return res;
    endfunction

    // status to the controller
    assign o_sts.last_round = (r_round == md5_pkg::LAST_ROUND);
    assign o_sts.fill_full  = &fill;
    assign o_sts.fill_le55  = (fill < md5_pkg::LEN_POS);

    assign o_digest = r_h[i_cmd.word_sel];

    // word fetch for the next round
    assign next_round = r_round + 6'd1;
    assign rd_idx     = i_cmd.prep ? 4'd0 : md5_pkg::f_pick(next_round);
    assign w          = f_pad_word(rd_idx, r_buf[rd_idx], i_cmd.mode, fill, bit_len);

    // round function
    always_comb begin
        unique case (r_round[5:4])
            2'd0: mix = (r_b & r_c) | (~r_b & r_d);
            2'd1: mix = (r_b & r_d) | (r_c & ~r_d);
            2'd2: mix = r_b ^ r_c ^ r_d;
            default: mix = r_c ^ (r_b | ~r_d);
        endcase
    end

    assign t   = r_pre + mix;
    assign sh  = md5_pkg::ROT_TABLE[{r_round[5:4], r_round[1:0]}];
    assign t2  = {t, t} << sh;
    assign n_b = r_b + t2[63:32];

    // next round's a is this round's d, so its sum is started during the round before
    assign n_pre = i_cmd.prep
        ? r_h[0] + w + md5_pkg::K_TABLE[6'd0]
        : r_d + w + md5_pkg::K_TABLE[next_round];

    // byte buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_buf[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= i_data_byte;
        end
    end

    // working variables and round counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_a     <= r_h[0];
            r_b     <= r_h[1];
            r_c     <= r_h[2];
            r_d     <= r_h[3];
            r_pre   <= n_pre;
            r_round <= 6'd0;
        end else if (i_cmd.step) begin
            r_a     <= r_d;
            r_b     <= n_b;
            r_c     <= r_b;
            r_d     <= r_c;
            r_pre   <= n_pre;
            r_round <= next_round;
        end
    end

    // chaining words and message length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_h[0]  <= md5_pkg::INIT_A;
            r_h[1]  <= md5_pkg::INIT_B;
            r_h[2]  <= md5_pkg::INIT_C;
            r_h[3]  <= md5_pkg::INIT_D;
            r_bytes <= '0;
        end else begin
            if (i_cmd.fold) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
            end
            if (i_cmd.wr_byte) begin
                r_bytes <= r_bytes + 61'd1;
            end
        end
    end

endmodule

FILE: sv/md5_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 digest over a byte stream, at most one byte per item, four digest words out.
// ----------------------------------------------------------------------------
// a byte that does not fill the block is stored and intake stays open
// a full block is compressed in a setup step, 64 rounds of the shared round unit and a fold
// message end: a pad step plus one or two padded blocks, then 4 output words
// no new byte is taken while a block is compressed or the digest is out
// synchronous active-low reset: initial chaining words, zero length, buffer kept
module md5_message_digest (
    input logic     i_clk,
    input logic     i_rst_n,
    md5_in_if.sink  i_in,
    md5_out_if.source o_out
);

    md5_pkg::t_cmd cmd;
    md5_pkg::t_sts sts;

    // sequencer
    md5_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_present   (i_in.byte_present),
        .i_eom       (i_in.end_of_message),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath
    md5_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in.data_byte),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_digest    (o_out.digest_word)
    );

    assign o_out.word_index = cmd.word_sel;
    assign o_out.last_word  = (cmd.word_sel == 2'd3);

    // no byte is taken while digest words are pending
    a_no_intake_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while digest is pending");

    // digest always starts at word A
    a_emit_starts_at_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> (o_out.word_index == 2'd0))
        else $error("digest output did not start at word A");

    // after the last word the block returns to intake
    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_word) |=> (i_in.ready && !o_out.valid))
        else $error("block did not return to intake after the digest");

endmodule

FILE: tb/md5_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_checker
// Watches the byte and digest channels, keeps its own MD5 state, predicts
// the four digest words of every finished message and compares each
// accepted word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module md5_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    md5_in_if    i_in,
    md5_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } t_digest_word;

    localparam int MAX_REPORTS = 10;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int LENGTH_AT = 56;

    localparam logic [31:0] CHAIN_SEED [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    // additive constant of each round
    localparam logic [31:0] ROUND_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // rotate amount per phase and round within the group of four
    localparam int ROUND_SHIFT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    logic [31:0]  chain [4];
    logic [63:0]  msg_bits;
    logic [7:0]   blk [64];
    logic [5:0]   fill;
    t_digest_word digest_queue [$];
    int           miss_count = 0;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // back to the initial chaining words with an empty message
    function automatic void restart_chain();
        for (int k = 0; k < 4; k++)
            chain[k] = CHAIN_SEED[k];
        msg_bits = '0;
        fill = '0;
    endfunction

    // 64 rounds over the buffered block, folded into the chaining words
    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, mix, t;
        int          pick;
        int          phase;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r+3], blk[4*r+2], blk[4*r+1], blk[4*r]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int r = 0; r < 64; r++) begin
            phase = r / 16;
            case (phase)
                0: begin
                    mix = (b & c) | (~b & d);
                    pick = r;
                end
                1: begin
                    mix = (b & d) | (c & ~d);
                    pick = 5 * r + 1;
                end
                2: begin
                    mix = b ^ c ^ d;
                    pick = 3 * r + 5;
                end
                default: begin
                    mix = c ^ (b | ~d);
                    pick = 7 * r;
                end
            endcase
            t = a + mix + w[pick % 16] + ROUND_ADD[r];
            a = d;
            d = c;
            c = b;
            b = b + rotl(t, ROUND_SHIFT[phase * 4 + r % 4]);
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endfunction

    // take one byte item; at message end pad, add length, queue the digest
    function automatic void absorb_item(input logic [7:0] data, input logic present,
                                        input logic eom);
        int          pos;
        logic [63:0] len;
        if (present) begin
            blk[fill] = data;
            msg_bits += 64'd8;
            fill = fill + 6'd1;
            if (fill == 6'd0)
                compress_block();
        end
        if (eom) begin
            len = msg_bits;
            pos = int'(fill);
            blk[pos] = PAD_BYTE;
            pos++;
            // no room left for the length: zero fill and an extra block
            if (pos > LENGTH_AT) begin
                while (pos < 64) begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < LENGTH_AT) begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int k = 0; k < 8; k++)
                blk[LENGTH_AT + k] = len[8*k +: 8];
            compress_block();
            for (int k = 0; k < 4; k++)
                digest_queue.push_back('{word: chain[k], index: 2'(k), last: (k == 3)});
            restart_chain();
        end
    endfunction

    // observe both channels at each edge
    always @(posedge i_clk) begin
        t_digest_word want;
        logic         bad;
        if (!i_rst_n) begin
            restart_chain();
            digest_queue.delete();
        end else begin
            // digest side first, a word can never stem from this edge's byte
            if (i_out.valid && i_out.ready) begin
                if (digest_queue.size() == 0) begin
                    miss_count++;
                    if (miss_count <= MAX_REPORTS)
                        $display("unexpected digest word %h index %0d last %0b",
                                 i_out.digest_word, i_out.word_index, i_out.last_word);
                end else begin
                    want = digest_queue.pop_front();
                    bad = (i_out.digest_word !== want.word)
                        || (i_out.word_index !== want.index)
                        || (i_out.last_word !== want.last);
                    if (bad) begin
                        miss_count++;
                        if (miss_count <= MAX_REPORTS)
                            $display("digest mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                                     want.word, want.index, want.last, i_out.digest_word,
                                     i_out.word_index, i_out.last_word);
                    end
                end
            end
            // byte side
            if (i_in.valid && i_in.ready)
                absorb_item(i_in.data_byte, i_in.byte_present, i_in.end_of_message);
        end
        o_fail_count <= miss_count;
        o_pending <= digest_queue.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds byte items into the MD5 block: a short directed set, then messages
// of random length and content with ignored items mixed in, under random
// idling on both channels and one long receiver hold-off. The checker
// predicts and compares; this module only drives and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RESET_CYCLES   = 8;
    localparam int IDLE_PERCENT   = 34;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_LEN       = 400;
    localparam int RX_STEADY_FROM = 750;
    localparam int RX_STEADY_TO   = 1000;
    localparam int TX_STEADY_FROM = 70;
    localparam int TX_STEADY_TO   = 120;
    localparam int TOTAL_BYTES    = 140;
    localparam int DRAIN_CYCLES   = 200;
    localparam int CYCLE_LIMIT    = 200000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   bytes_sent = 0;

    md5_in_if  byte_ch ();
    md5_out_if digest_ch ();

    md5_message_digest u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch.sink),
        .o_out   (digest_ch.source)
    );

    md5_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (byte_ch),
        .i_out        (digest_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // present one item after a random gap, return once it is accepted
    task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
        bit steady;
        steady = (bytes_sent >= TX_STEADY_FROM) && (bytes_sent < TX_STEADY_TO);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= data;
        byte_ch.byte_present <= present;
        byte_ch.end_of_message <= eom;
        @(posedge i_clk);
        while (!byte_ch.ready)
            @(posedge i_clk);
        if (present)
            bytes_sent++;
    endtask

    // one message of random bytes, ended on its last byte or by an empty item
    task automatic send_message(input int len);
        bit split_end;
        split_end = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
            // ignored item with neither byte nor end
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, !split_end && (i == len - 1));
        end
        if (split_end)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // stimulus
    initial begin
        i_rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.data_byte <= 8'h00;
        byte_ch.byte_present <= 1'b0;
        byte_ch.end_of_message <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty message, then an item that is ignored
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        // "abc", end on the last byte
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // extreme bytes, end by an empty item
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // single byte carrying the end
        send_item(8'h80, 1'b1, 1'b1);

        // tail too long for the length: two padding blocks
        send_message($urandom_range(56, 63));
        // exactly one full block before the padding
        send_message(64);
        while (bytes_sent < TOTAL_BYTES)
            send_message($urandom_range(0, 9));
        byte_ch.valid <= 1'b0;

        // wait for the last digest and some quiet time
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // digest receiver: random stalls, one long hold-off, one steady stretch
    initial begin
        int cyc;
        cyc = 0;
        digest_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN)
                digest_ch.ready <= 1'b0;
            else if (cyc >= RX_STEADY_FROM && cyc < RX_STEADY_TO)
                digest_ch.ready <= 1'b1;
            else
                digest_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
